// ===== src/fds_pkg.sv =====
// Shared types and constants of the fill dispense sequencer.
package fds_pkg;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_READY  = 3'd0,
        PH_WAIT   = 3'd1,
        PH_HALF   = 3'd2,
        PH_FULL   = 3'd3,
        PH_TAIL   = 3'd4,
        PH_FINISH = 3'd5
    } phase_t;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_LOW    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_HIGH   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_HOLD   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAIL        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_GUN_ON      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE    = 3'd6;

    localparam int CFG_DATA_W = 32;

    // Reset values of the configuration registers
    localparam logic [15:0] FREQ_LOW_RST    = 16'd5000;
    localparam logic [15:0] FREQ_HIGH_RST   = 16'd6000;
    localparam logic [15:0] HALF_HOLD_RST   = 16'd2000;
    localparam logic [31:0] TARGET_RST      = 32'd0;
    localparam logic [31:0] TAIL_RST        = 32'd0;
    localparam logic        GUN_ON_RST      = 1'b1;
    localparam logic [7:0]  DEBOUNCE_RST    = 8'd2;

    // Saturation value of the half-flow hold counter
    localparam logic [15:0] HOLD_MAX = 16'hffff;

    typedef struct packed {
        logic [15:0] freq_low;
        logic [15:0] freq_high;
        logic [15:0] half_hold_ticks;
        logic [31:0] target_amount;
        logic [31:0] tail_amount;
        logic        gun_on_level;
        logic [7:0]  debounce_period;
    } cfg_t;

    // Input beat, last field in the lowest bits
    typedef struct packed {
        logic        fill_permit;
        logic [15:0] flow_freq;
        logic [31:0] meter_count;
        logic        gun_pin;
    } in_item_t;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [31:0] dispensed;
        logic        gun_stable;
        logic        ready_notice;
        phase_t      phase;
        logic        aux_valve_on;
        logic        main_valve_on;
        logic        pump_on;
    } res_item_t;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

endpackage

// ===== src/fill_dispense_sequencer_top.sv =====
// Fill dispense sequencer top level: config registers, beat registers, assertions.
// Two register stages: an accepted beat waits in the input register and moves into the
// result register, which drives m_axis_tvalid, once that register is free or being taken.
// Throughput: one beat per cycle while m_axis_tready stays high; the input register feeds
// the sequencer and result register directly, so one tick is processed in every cycle that advances.
// Reset (aresetn low, synchronous): config registers take their defaults, phase is
// ready with a ready notice pending, debouncer and counters clear, no beat held.
module fill_dispense_sequencer_top #(
    parameter int METER_BITS      = 32,
    parameter int HISTORY_SAMPLES = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [fds_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [fds_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input ticks
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: gun_pin, meter_count, flow_freq, fill_permit
    input  logic [fds_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: pump_on, main_valve_on, aux_valve_on, phase, ready_notice,
    //        gun_stable, dispensed
    output logic [fds_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    fds_pkg::cfg_t      cfg_reg;
    fds_pkg::in_item_t  in_data_reg;
    fds_pkg::res_item_t out_data_reg, res;
    logic               in_valid_reg, out_valid_reg;
    logic               s_accept, advance, gun_level;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.freq_low        <= fds_pkg::FREQ_LOW_RST;
            cfg_reg.freq_high       <= fds_pkg::FREQ_HIGH_RST;
            cfg_reg.half_hold_ticks <= fds_pkg::HALF_HOLD_RST;
            cfg_reg.target_amount   <= fds_pkg::TARGET_RST;
            cfg_reg.tail_amount     <= fds_pkg::TAIL_RST;
            cfg_reg.gun_on_level    <= fds_pkg::GUN_ON_RST;
            cfg_reg.debounce_period <= fds_pkg::DEBOUNCE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                fds_pkg::CFG_FREQ_LOW:  cfg_reg.freq_low        <= cfg_wdata[15:0];
                fds_pkg::CFG_FREQ_HIGH: cfg_reg.freq_high       <= cfg_wdata[15:0];
                fds_pkg::CFG_HALF_HOLD: cfg_reg.half_hold_ticks <= cfg_wdata[15:0];
                fds_pkg::CFG_TARGET:    cfg_reg.target_amount   <= cfg_wdata[31:0];
                fds_pkg::CFG_TAIL:      cfg_reg.tail_amount     <= cfg_wdata[31:0];
                fds_pkg::CFG_GUN_ON:    cfg_reg.gun_on_level    <= cfg_wdata[0];
                fds_pkg::CFG_DEBOUNCE:  cfg_reg.debounce_period <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result register frees
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Beat payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= fds_pkg::in_item_t'(s_axis_tdata[$bits(fds_pkg::in_item_t)-1:0]);
        end
        if (advance) begin
            out_data_reg <= res;
        end
    end

    fds_debounce #(
        .HISTORY_SAMPLES (HISTORY_SAMPLES)
    ) u_debounce (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .gun_pin    (in_data_reg.gun_pin),
        .period_cfg (cfg_reg.debounce_period),
        .level_now  (gun_level)
    );

    fds_sequencer #(
        .METER_BITS (METER_BITS)
    ) u_sequencer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_data_reg),
        .cfg       (cfg_reg),
        .gun_level (gun_level),
        .result    (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = fds_pkg::OUT_TDATA_W'(out_data_reg);

`ifndef SYNTHESIS
    // A held tick is not overwritten while the result side stalls
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input beat register changed while stalled");

    // The ready notice only comes from the ready phase
    a_notice_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.ready_notice) |->
        (out_data_reg.phase == fds_pkg::PH_READY))
        else $error("ready notice outside ready phase");

    // Pump runs exactly in the filling and finish phases
    a_pump_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.pump_on ==
        ((out_data_reg.phase != fds_pkg::PH_READY) &&
         (out_data_reg.phase != fds_pkg::PH_WAIT))))
        else $error("pump drive does not match phase");

    // A result is produced only from a held input tick
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg && !in_valid_reg) |=> !out_valid_reg)
        else $error("result beat without an input beat");
`endif

endmodule

// ===== src/fds_debounce.sv =====
// Nozzle pin sample divider and hysteresis debouncer.
module fds_debounce #(
    parameter int HISTORY_SAMPLES = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       gun_pin,
    input  logic [7:0] period_cfg,
    output logic       level_now
);

    localparam int HW = HISTORY_SAMPLES - 1;

    logic [HW-1:0] hist_reg, hist_next;
    logic [7:0]    div_reg, div_next, div_inc, period;
    logic          level_reg, level_next;
    logic          sample, all_hi, any_hi;

    // Divider, then a sample against the held history
    always_comb begin
        period     = (period_cfg == 8'd0) ? 8'd1 : period_cfg;
        div_inc    = div_reg + 8'd1;
        sample     = !(div_inc < period);
        div_next   = sample ? 8'd0 : div_inc;
        all_hi     = gun_pin && (&hist_reg);
        any_hi     = gun_pin || (|hist_reg);
        level_next = level_reg;
        hist_next  = hist_reg;
        if (sample) begin
            if (all_hi) begin
                level_next = 1'b1;
            end else if (!any_hi) begin
                level_next = 1'b0;
            end
            hist_next = HW'({hist_reg, gun_pin});
        end
    end

    assign level_now = level_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= '0;
            div_reg   <= 8'd0;
            level_reg <= 1'b0;
        end else if (step) begin
            hist_reg  <= hist_next;
            div_reg   <= div_next;
            level_reg <= level_next;
        end
    end

endmodule

// ===== src/fds_sequencer.sv =====
// Six-phase fill sequencer with hold counter and dispensed amount.
module fds_sequencer #(
    parameter int METER_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  fds_pkg::in_item_t   item,
    input  fds_pkg::cfg_t       cfg,
    input  logic                gun_level,
    output fds_pkg::res_item_t  result
);

    localparam int CW = (METER_BITS > 32) ? METER_BITS : 32;

    fds_pkg::phase_t         phase_reg, phase_next;
    logic [15:0]             hold_reg, hold_next, hold_inc;
    logic [METER_BITS-1:0]   start_reg, start_next, meter_m, disp;
    logic                    notice_reg, notice_next;
    logic                    on, in_window, pump, mainv, aux, notice;
    logic [31:0]             tail_thr;

    // Phase logic, drives and result for the current tick
    always_comb begin
        on          = (gun_level == cfg.gun_on_level);
        meter_m     = METER_BITS'(item.meter_count);
        disp        = meter_m - start_reg;
        tail_thr    = (cfg.target_amount >= cfg.tail_amount) ?
                      (cfg.target_amount - cfg.tail_amount) : 32'd0;
        in_window   = (item.flow_freq >= cfg.freq_low) &&
                      (item.flow_freq <= cfg.freq_high);
        hold_inc    = (hold_reg != fds_pkg::HOLD_MAX) ? hold_reg + 16'd1 : hold_reg;
        phase_next  = phase_reg;
        hold_next   = hold_reg;
        start_next  = start_reg;
        notice_next = notice_reg;
        pump        = 1'b0;
        mainv       = 1'b0;
        aux         = 1'b0;
        notice      = 1'b0;
        unique case (phase_reg)
            fds_pkg::PH_WAIT: begin
                if (!on) begin
                    start_next = meter_m;
                    hold_next  = 16'd0;
                    phase_next = fds_pkg::PH_HALF;
                end
            end
            fds_pkg::PH_HALF: begin
                pump = 1'b1;
                aux  = 1'b1;
                if (in_window) begin
                    hold_next = hold_inc;
                    if (hold_inc >= cfg.half_hold_ticks) begin
                        phase_next = fds_pkg::PH_FULL;
                    end
                end else begin
                    hold_next = 16'd0;
                end
                if (!on) begin
                    phase_next = fds_pkg::PH_FINISH;
                end
            end
            fds_pkg::PH_FULL: begin
                pump  = 1'b1;
                mainv = 1'b1;
                aux   = 1'b1;
                if (CW'(disp) > CW'(tail_thr)) begin
                    phase_next = fds_pkg::PH_TAIL;
                end
                if (!on) begin
                    phase_next = fds_pkg::PH_FINISH;
                end
            end
            fds_pkg::PH_TAIL: begin
                pump  = 1'b1;
                mainv = 1'b1;
                if ((CW'(disp) > CW'(cfg.target_amount)) || !on) begin
                    phase_next = fds_pkg::PH_FINISH;
                end
            end
            fds_pkg::PH_FINISH: begin
                pump  = 1'b1;
                mainv = 1'b1;
                aux   = 1'b1;
                if (!on) begin
                    phase_next = fds_pkg::PH_READY;
                end
            end
            default: begin
                // ready, and any unused code falls back to ready
                notice      = notice_reg;
                notice_next = 1'b0;
                phase_next  = fds_pkg::PH_READY;
                if (on && item.fill_permit) begin
                    phase_next  = fds_pkg::PH_WAIT;
                    notice_next = 1'b1;
                end
            end
        endcase

        result.pump_on       = pump;
        result.main_valve_on = mainv;
        result.aux_valve_on  = aux;
        result.phase         = (phase_reg > fds_pkg::PH_FINISH) ?
                               fds_pkg::PH_READY : phase_reg;
        result.ready_notice  = notice;
        result.gun_stable    = gun_level;
        result.dispensed     = 32'(disp);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= fds_pkg::PH_READY;
            hold_reg   <= 16'd0;
            start_reg  <= '0;
            notice_reg <= 1'b1;
        end else if (step) begin
            phase_reg  <= phase_next;
            hold_reg   <= hold_next;
            start_reg  <= start_next;
            notice_reg <= notice_next;
        end
    end

endmodule
